// ===== design/crk_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package crk_pkg;

    localparam int TIME_BITS_DEFAULT  = 32;
    localparam int DEG_PER_TOOTH_DEF  = 6;

    // Quotient width of the shared divider: covers 168000000
    localparam int QUO_BITS   = 28;
    // Width of speed * degrees per tooth (speed <= 1000000, degrees <= 30)
    localparam int DENOM_BITS = 25;
    localparam int SPEED_BITS = 20;

    localparam logic [QUO_BITS-1:0] SPD_NUM = 28'd1000000;
    localparam logic [QUO_BITS-1:0] TDC_NUM = 28'd168000000;
    localparam logic [QUO_BITS-1:0] INJ_NUM = 28'd138000000;
    localparam logic [10:0]         INJ_OPEN_US    = 11'd1700;
    localparam logic [11:0]         COIL_CHARGE_US = 12'd3000;

    // Register indexes
    localparam logic [1:0] REG_FUEL_EN  = 2'd0;
    localparam logic [1:0] REG_FUEL_T   = 2'd1;
    localparam logic [1:0] REG_ADV_EN   = 2'd2;
    localparam logic [1:0] REG_ADV_T    = 2'd3;

    typedef struct packed {
        logic [31:0] edge_time;
        logic [11:0] throttle;
    } crk_in_t;

    typedef struct packed {
        logic        injector_on;
        logic        coil_level;
        logic [15:0] tooth_angle;
        logic        cycle_phase;
        logic        gap_seen;
        logic [19:0] speed_value;
    } crk_out_t;

    typedef struct packed {
        logic        fuel_override_enable;
        logic [15:0] fuel_override_time;
        logic        advance_override_enable;
        logic [15:0] advance_override_time;
    } crk_cfg_t;

    localparam logic [11:0] THR_BINS [0:9] = '{
        12'd167, 12'd410, 12'd819, 12'd1229, 12'd1638,
        12'd2048, 12'd2457, 12'd2867, 12'd3276, 12'd3686};

    localparam logic [19:0] SPD_BINS [0:11] = '{
        20'd50, 20'd100, 20'd150, 20'd500, 20'd1000, 20'd1500,
        20'd2000, 20'd2500, 20'd3000, 20'd3500, 20'd4000, 20'd4500};

    localparam logic [15:0] INJ_MAP [0:10] = '{
        16'd0, 16'd546, 16'd1091, 16'd1637, 16'd2182, 16'd2728,
        16'd3273, 16'd3819, 16'd4364, 16'd4910, 16'd5455};

    localparam logic [15:0] ADV_MAP [0:10][0:12] = '{
        '{16'd16667, 16'd9148, 16'd7218, 16'd2562, 16'd1516, 16'd1196, 16'd1062,
          16'd1005, 16'd991, 16'd1006, 16'd1041, 16'd1095, 16'd1167},
        '{16'd16667, 16'd9333, 16'd6556, 16'd2667, 16'd1833, 16'd1556, 16'd1417,
          16'd1333, 16'd1278, 16'd1238, 16'd1208, 16'd1185, 16'd1167},
        '{16'd16667, 16'd9333, 16'd6549, 16'd2573, 16'd1714, 16'd1423, 16'd1289,
          16'd1207, 16'd1150, 16'd1108, 16'd1074, 16'd1043, 16'd1016},
        '{16'd16667, 16'd9333, 16'd6542, 16'd2483, 16'd1603, 16'd1302, 16'd1173,
          16'd1092, 16'd1035, 16'd992, 16'd955, 16'd918, 16'd885},
        '{16'd16667, 16'd9333, 16'd6536, 16'd2396, 16'd1499, 16'd1192, 16'd1068,
          16'd988, 16'd932, 16'd888, 16'd849, 16'd808, 16'd771},
        '{16'd16667, 16'd9333, 16'd6529, 16'd2312, 16'd1401, 16'd1090, 16'd971,
          16'd894, 16'd838, 16'd794, 16'd755, 16'd711, 16'd671},
        '{16'd16667, 16'd9333, 16'd6523, 16'd2232, 16'd1310, 16'd998, 16'd884,
          16'd809, 16'd755, 16'd711, 16'd671, 16'd625, 16'd585},
        '{16'd16667, 16'd9333, 16'd6516, 16'd2153, 16'd1225, 16'd913, 16'd804,
          16'd733, 16'd679, 16'd636, 16'd596, 16'd550, 16'd509},
        '{16'd16667, 16'd9333, 16'd6510, 16'd2078, 16'd1145, 16'd835, 16'd732,
          16'd663, 16'd611, 16'd570, 16'd530, 16'd484, 16'd444},
        '{16'd16667, 16'd9333, 16'd6503, 16'd2005, 16'd1071, 16'd764, 16'd666,
          16'd600, 16'd550, 16'd510, 16'd471, 16'd426, 16'd386},
        '{16'd16667, 16'd9333, 16'd6497, 16'd1935, 16'd1001, 16'd699, 16'd606,
          16'd543, 16'd495, 16'd456, 16'd419, 16'd375, 16'd337}};

    // Throttle bin: index of the last threshold reached, plus one
    function automatic logic [3:0] thr_row(input logic [11:0] thr);
        logic [3:0] r;
        r = 4'd0;
        for (int i = 0; i < 10; i++)
        begin
            if (thr >= THR_BINS[i])
                r = 4'(i + 1);
        end
        return r;
    endfunction

    // Speed bin
    function automatic logic [3:0] spd_col(input logic [19:0] spd);
        logic [3:0] c;
        c = 4'd0;
        for (int i = 0; i < 12; i++)
        begin
            if (spd >= SPD_BINS[i])
                c = 4'(i + 1);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== design/crank_sync_injection_ignition_timer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Crank tooth decoder with fuel and spark scheduling.
// Edge channel: each transaction carries one rising tooth edge timestamp
// (microseconds, free running) and a throttle sample. Result channel: one
// transaction per edge with injector and coil levels, tooth angle, engine
// cycle half, the gap flag and the speed used.
// Configuration: APB registers at 0x0 fuel override enable, 0x4 fuel
// override time, 0x8 advance override enable, 0xC advance override time.
// A single bit-serial divider runs three 28-step divisions in turn (speed,
// TDC time, injection start), each opened by a start pulse and closed by a
// done pulse, and the block takes one edge at a time, so edge_ready returns
// in the cycle after the result is written.
// When the receiver stalls, the finished result waits in the output
// register and the block holds its state update until the result slot is
// free. Reset clears all timing state, the registers and the result valid.
module crank_sync_injection_ignition_timer
    import crk_pkg::*;
#(
    parameter int TIME_BITS         = TIME_BITS_DEFAULT,
    parameter int DEGREES_PER_TOOTH = DEG_PER_TOOTH_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        edge_valid,
    output logic             edge_ready,
    input  wire crk_in_t     edge_data,
    output logic             result_valid,
    input  wire logic        result_ready,
    output crk_out_t         result_data,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int DVS_W = (TIME_BITS > DENOM_BITS) ? TIME_BITS : DENOM_BITS;
    localparam int GAP_W = TIME_BITS + 5;
    localparam int CMP_W = (TIME_BITS > 30) ? TIME_BITS : 30;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SPD    = 7'b0000010,
        S_TDC_GO = 7'b0000100,
        S_TDC    = 7'b0001000,
        S_INJ_GO = 7'b0010000,
        S_INJ    = 7'b0100000,
        S_FIN    = 7'b1000000
    } crk_state_t;

    crk_state_t state_reg, state_next;

    crk_cfg_t cfg;

    // Timing state; the stored period doubles as the previous period
    logic [TIME_BITS-1:0] last_edge_reg, period_reg, sync_time_reg;
    logic [15:0]          angle_reg;
    logic                 sync_pending_reg, cycle_reg, armed_reg, inj_level_reg, coil_reg;

    // Per-edge working registers
    logic [TIME_BITS-1:0]  now_reg;
    logic [11:0]           thr_reg;
    logic [SPEED_BITS-1:0] speed_reg;
    logic [QUO_BITS-1:0]   tdc_reg, inj_reg;

    logic     out_valid_reg;
    crk_out_t out_data_reg;

    // Divider hookup
    logic                div_start, div_done;
    logic [QUO_BITS-1:0] div_dividend, div_quo;
    logic [DVS_W-1:0]    div_divisor;
    logic [DENOM_BITS-1:0] denom;

    crk_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    crk_div #(.DVS_W(DVS_W)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    logic accept_in, slot_free, commit;

    assign edge_ready   = (state_reg == S_IDLE);
    assign accept_in    = edge_valid && edge_ready;
    assign slot_free    = !out_valid_reg || result_ready;
    assign commit       = (state_reg == S_FIN) && slot_free;
    assign result_valid = out_valid_reg;
    assign result_data  = out_data_reg;

    assign denom = DENOM_BITS'(speed_reg) * DENOM_BITS'(DEGREES_PER_TOOTH);

    // Drive the divider: period first, then the two angle times
    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = SPD_NUM;
        div_divisor  = DVS_W'(period_reg);
        case (state_reg)
            S_IDLE:
            begin
                div_start = accept_in;
            end
            S_TDC_GO:
            begin
                div_start    = 1'b1;
                div_dividend = TDC_NUM;
                div_divisor  = DVS_W'(denom);
            end
            S_INJ_GO:
            begin
                div_start    = 1'b1;
                div_dividend = INJ_NUM;
                div_divisor  = DVS_W'(denom);
            end
            default: ;
        endcase
    end

    // Sequence the steps of one edge
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (accept_in) state_next = S_SPD;
            S_SPD:    if (div_done)  state_next = S_TDC_GO;
            S_TDC_GO: state_next = S_TDC;
            S_TDC:    if (div_done)  state_next = S_INJ_GO;
            S_INJ_GO: state_next = S_INJ;
            S_INJ:    if (div_done)  state_next = S_FIN;
            S_FIN:    if (slot_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Final update, all from registered operands
    logic [TIME_BITS-1:0] new_period, sync_t_eff, elapsed;
    logic                 cycle_eff, armed_eff, gap;
    logic [GAP_W-1:0]     prev_x21, cur_x20;
    logic [3:0]           row, col;
    logic [15:0]          inj_use, adv;
    logic [QUO_BITS:0]    off_th;
    logic signed [29:0]   fire_th, charge_th;
    logic [CMP_W-1:0]     el_ext;
    logic                 inj_level_new, armed_new, coil_new;

    always_comb
    begin
        new_period = now_reg - last_edge_reg;
        cycle_eff  = sync_pending_reg ? !cycle_reg : cycle_reg;
        armed_eff  = sync_pending_reg ? 1'b1 : armed_reg;
        sync_t_eff = sync_pending_reg ? now_reg : sync_time_reg;

        prev_x21 = GAP_W'(period_reg) * GAP_W'(21);
        cur_x20  = GAP_W'(new_period) * GAP_W'(20);
        gap      = prev_x21 < cur_x20;

        elapsed = now_reg - sync_t_eff;
        el_ext  = CMP_W'(elapsed);

        row     = thr_row(thr_reg);
        col     = spd_col(speed_reg);
        inj_use = cfg.fuel_override_enable ? cfg.fuel_override_time : INJ_MAP[row];
        adv     = cfg.advance_override_enable ? cfg.advance_override_time
                                              : ADV_MAP[row][col];

        // Injector window, only in the injection revolution while armed
        off_th        = (QUO_BITS+1)'(inj_reg) + (QUO_BITS+1)'(INJ_OPEN_US)
                        + (QUO_BITS+1)'(inj_use);
        inj_level_new = inj_level_reg;
        armed_new     = armed_eff;
        if (!cycle_eff && armed_eff)
        begin
            if (el_ext >= CMP_W'(inj_reg))
                inj_level_new = 1'b1;
            if (el_ext >= CMP_W'(off_th))
            begin
                inj_level_new = 1'b0;
                armed_new     = 1'b0;
            end
        end

        // Coil: skip thresholds that fall below zero
        fire_th   = $signed({2'b00, tdc_reg}) - $signed({14'd0, adv});
        charge_th = fire_th - $signed({18'd0, COIL_CHARGE_US});
        coil_new  = coil_reg;
        if (!charge_th[29] && el_ext >= CMP_W'(charge_th[28:0]))
            coil_new = 1'b0;
        if (!fire_th[29] && el_ext >= CMP_W'(fire_th[28:0]))
            coil_new = 1'b1;
    end

    // Control and timing state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            out_valid_reg    <= 1'b0;
            last_edge_reg    <= '0;
            period_reg       <= '0;
            sync_time_reg    <= '0;
            angle_reg        <= '0;
            sync_pending_reg <= 1'b0;
            cycle_reg        <= 1'b0;
            armed_reg        <= 1'b0;
            inj_level_reg    <= 1'b0;
            coil_reg         <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
                out_valid_reg <= 1'b1;
            else if (result_valid && result_ready)
                out_valid_reg <= 1'b0;
            if (commit)
            begin
                period_reg       <= new_period;
                last_edge_reg    <= now_reg;
                sync_time_reg    <= sync_t_eff;
                cycle_reg        <= cycle_eff;
                sync_pending_reg <= gap;
                angle_reg        <= gap ? 16'd0 : angle_reg + 16'(DEGREES_PER_TOOTH);
                armed_reg        <= armed_new;
                inj_level_reg    <= inj_level_new;
                coil_reg         <= coil_new;
            end
        end
    end

    // Working registers and result payload
    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            now_reg <= TIME_BITS'(edge_data.edge_time);
            thr_reg <= edge_data.throttle;
        end
        if (state_reg == S_SPD && div_done)
        begin
            if (period_reg == '0 || div_quo == '0)
                speed_reg <= SPEED_BITS'(1);
            else
                speed_reg <= div_quo[SPEED_BITS-1:0];
        end
        if (state_reg == S_TDC && div_done)
            tdc_reg <= div_quo;
        if (state_reg == S_INJ && div_done)
            inj_reg <= div_quo;
        if (commit)
        begin
            out_data_reg.injector_on <= inj_level_new;
            out_data_reg.coil_level  <= coil_new;
            out_data_reg.tooth_angle <= gap ? 16'd0 : angle_reg + 16'(DEGREES_PER_TOOTH);
            out_data_reg.cycle_phase <= cycle_eff;
            out_data_reg.gap_seen    <= gap;
            out_data_reg.speed_value <= speed_reg;
        end
    end

endmodule
`default_nettype wire

// ===== design/crk_apb_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
module crk_apb_regs
    import crk_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output crk_cfg_t         cfg
);

    crk_cfg_t   cfg_reg;
    logic [1:0] idx;
    logic       wr_en;

    assign idx    = paddr[3:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // Write the addressed register in the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_FUEL_EN: cfg_reg.fuel_override_enable    <= pwdata[0];
                REG_FUEL_T:  cfg_reg.fuel_override_time      <= pwdata[15:0];
                REG_ADV_EN:  cfg_reg.advance_override_enable <= pwdata[0];
                REG_ADV_T:   cfg_reg.advance_override_time   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        case (idx)
            REG_FUEL_EN: prdata = {31'd0, cfg_reg.fuel_override_enable};
            REG_FUEL_T:  prdata = {16'd0, cfg_reg.fuel_override_time};
            REG_ADV_EN:  prdata = {31'd0, cfg_reg.advance_override_enable};
            REG_ADV_T:   prdata = {16'd0, cfg_reg.advance_override_time};
            default:     prdata = 32'd0;
        endcase
    end

endmodule
`default_nettype wire

// ===== design/crk_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module crk_div
    import crk_pkg::*;
#(
    parameter int DVS_W = 32
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [QUO_BITS-1:0]  dividend,
    input  wire logic [DVS_W-1:0]     divisor,
    output logic                      done,
    output logic [QUO_BITS-1:0]       quotient
);

    localparam int CNT_W = $clog2(QUO_BITS + 1);

    logic [QUO_BITS-1:0] quo_reg;
    logic [DVS_W-1:0]    rem_reg;
    logic [DVS_W-1:0]    dvs_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                busy_reg;
    logic                done_reg;
    logic [DVS_W:0]      trial;
    logic [DVS_W:0]      diff;
    logic                fits;
    logic                last_step;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    assign trial = {rem_reg, quo_reg[QUO_BITS-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = (trial >= {1'b0, dvs_reg});

    assign last_step = busy_reg && (cnt_reg == CNT_W'(QUO_BITS - 1));

    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= last_step;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last_step)
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[QUO_BITS-2:0], fits};
            rem_reg <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        end
    end

endmodule
`default_nettype wire

// ===== design/crk_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module crk_checker
    import crk_pkg::*;
(
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     edge_valid,
    input wire logic     edge_ready,
    input wire logic     result_valid,
    input wire logic     result_ready,
    input wire crk_out_t result_data
);

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_data))
        else $error("stalled result changed");

    // One edge at a time: busy right after an accepted edge
    assert property (@(posedge clk) disable iff (!rst_n)
        edge_valid && edge_ready |=> !edge_ready)
        else $error("edge accepted while busy");

    // Speed is floored at one
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result_data.speed_value != 20'd0)
        else $error("zero speed reported");

    // The gap restarts the angle count
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_data.gap_seen |-> result_data.tooth_angle == 16'd0)
        else $error("angle not cleared at gap");

endmodule

bind crank_sync_injection_ignition_timer crk_checker u_crk_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .edge_valid   (edge_valid),
    .edge_ready   (edge_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data)
);
`default_nettype wire
